### src/taxp_pkg.sv
`timescale 1ns / 1ps

package taxp_pkg;

   // Port widths fixed by the request and result formats
   localparam int PAYLOAD_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 4;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEF = 8;
   localparam int WORD_BITS_DEF = 64;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_DIM_ONE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM_TWO = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM_THREE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM_FOUR = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SWAP_FIRST = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SWAP_SECOND = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SWAP_PAIRS = 3'd6;

   // Request kinds carried on req_tuser
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Control from the top level to the load address generator
   typedef struct packed {
      logic clear;
      logic advance;
   } load_ctl_type;

endpackage

### src/taxp_load_addr.sv
`timescale 1ns / 1ps

// Source coordinate counters and target-layout address for load requests.
// Each source axis keeps its coordinate and the matching partial address
// (coordinate times its target stride), so the address is a four-term sum.
module taxp_load_addr #(
   parameter int MAX_DIM = taxp_pkg::MAX_DIM_DEF,
   parameter int EXT_W = $clog2(MAX_DIM + 1),
   parameter int ADDR_W = $clog2(MAX_DIM ** 4)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  taxp_pkg::load_ctl_type     ctl,
   input  logic [3:0][EXT_W-1:0]      ext,    // clamped source extents
   input  logic [3:0][1:0]            order,  // source axis at each target slot
   output logic [ADDR_W-1:0]          addr
);

   localparam int CRD_W = $clog2(MAX_DIM);

   logic [3:0][CRD_W-1:0]  coord_ff, coord_in;
   logic [3:0][ADDR_W-1:0] part_ff, part_in;
   logic [3:0][ADDR_W-1:0] slot_stride;
   logic [3:0][ADDR_W-1:0] axis_stride;
   logic [3:0]             wrap;
   logic [3:0]             step;

   // Target strides: product of the extents in the faster target slots
   always_comb begin
      slot_stride[3] = ADDR_W'(1);
      slot_stride[2] = ADDR_W'(ext[order[3]]);
      slot_stride[1] = ADDR_W'(ADDR_W'(ext[order[2]]) * ADDR_W'(ext[order[3]]));
      slot_stride[0] = ADDR_W'(slot_stride[1] * ADDR_W'(ext[order[1]]));
   end

   // Map target strides back onto source axes
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         axis_stride[a] = '0;
         for (int k = 0; k < 4; k++) begin
            if (order[k] == 2'(a)) begin
               axis_stride[a] = slot_stride[k];
            end
         end
      end
   end

   // Source axis four runs fastest; carry ripples toward axis one
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         wrap[a] = (EXT_W'(coord_ff[a]) == EXT_W'(ext[a] - EXT_W'(1)));
      end
      step[3] = 1'b1;
      for (int a = 2; a >= 0; a--) begin
         step[a] = step[a+1] & wrap[a+1];
      end
      for (int a = 0; a < 4; a++) begin
         coord_in[a] = coord_ff[a];
         part_in[a] = part_ff[a];
         if (step[a]) begin
            coord_in[a] = wrap[a] ? '0 : CRD_W'(coord_ff[a] + CRD_W'(1));
            part_in[a] = wrap[a] ? '0 : ADDR_W'(part_ff[a] + axis_stride[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         coord_ff <= '0;
         part_ff <= '0;
      end else if (ctl.advance) begin
         coord_ff <= coord_in;
         part_ff <= part_in;
      end
   end

   assign addr = ADDR_W'(part_ff[0] + part_ff[1] + part_ff[2] + part_ff[3]);

endmodule

### src/tensor_axis_permute_4d.sv
`timescale 1ns / 1ps

// Four-axis reorder of a small 4-D block of words.
//
// Requests enter on the req_ channel; req_tuser selects the kind: a load
// stores req_tdata at the target-layout address of the next source
// coordinate (source axis four fastest) and returns nothing; a read returns
// the next stored word in target row-major order on the rsp_ channel, with
// rsp_tlast on the final word of the block. Both counters wrap on their own.
// Configure over the csr_ port: four extents (0 taken as 1, values above
// MAX_DIM taken as MAX_DIM) and three order flags. Any write to a defined
// register restarts both the load and the read position.
//
// Throughput is one request per cycle, loads and reads mixed freely. A
// read passes the registered memory read and then the output register on
// its way to rsp_. The memory has a single write and a single read port;
// the read pipe plus output register form a two-entry buffer, so requests
// keep flowing while one result waits. When the receiver stalls and both
// entries are full, req_tready drops. Reset clears the counters, flags and
// extents (extents to 1); store contents are not cleared.
module tensor_axis_permute_4d #(
   parameter int MAX_DIM = taxp_pkg::MAX_DIM_DEF,
   parameter int WORD_BITS = taxp_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [taxp_pkg::PAYLOAD_W-1:0]      req_tdata,   // [63:0] word
   input  logic                                req_tuser,   // [0] action
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [taxp_pkg::PAYLOAD_W-1:0]      rsp_tdata,   // [63:0] word_out
   output logic                                rsp_tlast,
   // Register write port
   input  logic                                csr_we,
   input  logic [taxp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [taxp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int EXT_W = $clog2(MAX_DIM + 1);
   localparam int CRD_W = $clog2(MAX_DIM);
   localparam int DEPTH = MAX_DIM ** 4;
   localparam int ADDR_W = $clog2(DEPTH);

   // Configuration registers
   logic [3:0][EXT_W-1:0] ext_ff;
   logic                  swap_first_ff, swap_second_ff, swap_pairs_ff;
   logic [EXT_W-1:0]      ext_wr;
   logic                  cfg_hit;

   // Target order and read position
   logic [3:0][1:0]       order;
   logic [ADDR_W-1:0]     read_idx_ff, read_idx_in;
   logic [3:0][CRD_W-1:0] rd_crd_ff, rd_crd_in;
   logic [3:0]            rd_wrap, rd_step;
   logic                  rd_last;

   // Handshake and pipeline
   logic                  req_accept, ld_accept, rd_accept;
   logic                  s1_valid_ff, s1_last_ff;
   logic                  s1_move;
   logic                  out_valid_ff, out_last_ff;
   logic [WORD_BITS-1:0]  out_word_ff;
   logic [WORD_BITS-1:0]  mem_q_ff;
   logic [WORD_BITS-1:0]  mem [DEPTH];
   logic [ADDR_W-1:0]     ld_addr;
   taxp_pkg::load_ctl_type ld_ctl;

   // Clamp an extent on its way in
   always_comb begin
      if (csr_wdata == '0) begin
         ext_wr = EXT_W'(1);
      end else if (int'(csr_wdata) > MAX_DIM) begin
         ext_wr = EXT_W'(MAX_DIM);
      end else begin
         ext_wr = EXT_W'(csr_wdata);
      end
   end

   assign cfg_hit = csr_we && (csr_addr <= taxp_pkg::REG_SWAP_PAIRS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 4; a++) ext_ff[a] <= EXT_W'(1);
         swap_first_ff <= 1'b0;
         swap_second_ff <= 1'b0;
         swap_pairs_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            taxp_pkg::REG_DIM_ONE:     ext_ff[0] <= ext_wr;
            taxp_pkg::REG_DIM_TWO:     ext_ff[1] <= ext_wr;
            taxp_pkg::REG_DIM_THREE:   ext_ff[2] <= ext_wr;
            taxp_pkg::REG_DIM_FOUR:    ext_ff[3] <= ext_wr;
            taxp_pkg::REG_SWAP_FIRST:  swap_first_ff <= csr_wdata[0];
            taxp_pkg::REG_SWAP_SECOND: swap_second_ff <= csr_wdata[0];
            taxp_pkg::REG_SWAP_PAIRS:  swap_pairs_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Base order 1234 or 3412, then optional swaps within each pair
   always_comb begin
      if (swap_pairs_ff) begin
         order[0] = 2'd2; order[1] = 2'd3; order[2] = 2'd0; order[3] = 2'd1;
      end else begin
         order[0] = 2'd0; order[1] = 2'd1; order[2] = 2'd2; order[3] = 2'd3;
      end
      if (swap_first_ff) begin
         order[0] = swap_pairs_ff ? 2'd3 : 2'd1;
         order[1] = swap_pairs_ff ? 2'd2 : 2'd0;
      end
      if (swap_second_ff) begin
         order[2] = swap_pairs_ff ? 2'd1 : 2'd3;
         order[3] = swap_pairs_ff ? 2'd0 : 2'd2;
      end
   end

   // Accept while the read pipe can move or has room
   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !out_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign ld_accept = req_accept && (req_tuser == taxp_pkg::ACT_LOAD);
   assign rd_accept = req_accept && (req_tuser == taxp_pkg::ACT_READ);

   assign ld_ctl.clear = cfg_hit;
   assign ld_ctl.advance = ld_accept;

   taxp_load_addr #(
      .MAX_DIM (MAX_DIM),
      .EXT_W   (EXT_W),
      .ADDR_W  (ADDR_W)
   ) u_load_addr (
      .clock (clock),
      .reset (reset),
      .ctl   (ld_ctl),
      .ext   (ext_ff),
      .order (order),
      .addr  (ld_addr)
   );

   // Read position: linear address plus per-slot counters for the end test
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rd_wrap[k] = (EXT_W'(rd_crd_ff[k]) == EXT_W'(ext_ff[order[k]] - EXT_W'(1)));
      end
      rd_step[3] = 1'b1;
      for (int k = 2; k >= 0; k--) begin
         rd_step[k] = rd_step[k+1] & rd_wrap[k+1];
      end
      rd_last = &rd_wrap;
      for (int k = 0; k < 4; k++) begin
         rd_crd_in[k] = rd_crd_ff[k];
         if (rd_step[k]) begin
            rd_crd_in[k] = rd_wrap[k] ? '0 : CRD_W'(rd_crd_ff[k] + CRD_W'(1));
         end
      end
      read_idx_in = rd_last ? '0 : ADDR_W'(read_idx_ff + ADDR_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         read_idx_ff <= '0;
         rd_crd_ff <= '0;
      end else if (rd_accept) begin
         read_idx_ff <= read_idx_in;
         rd_crd_ff <= rd_crd_in;
      end
   end

   // Element store: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (ld_accept) begin
         mem[ld_addr] <= req_tdata[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_accept) begin
         mem_q_ff <= mem[read_idx_ff];
      end
   end

   // Read pipe stage: hold until the output register frees
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rd_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_accept) begin
         s1_last_ff <= rd_last;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_word_ff <= mem_q_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = taxp_pkg::PAYLOAD_W'(out_word_ff);
   assign rsp_tlast = out_last_ff;

   // A stalled pipe with a full output register must refuse requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while read pipe is full");

   // An accepted read occupies the pipe stage next cycle
   a_read_enters: assert property (@(posedge clock) disable iff (reset)
      rd_accept |=> s1_valid_ff)
      else $error("accepted read lost");

   // The final read of a block wraps the read position
   a_read_wrap: assert property (@(posedge clock) disable iff (reset)
      (rd_accept && rd_last) |=> (read_idx_ff == '0))
      else $error("read position did not wrap after last");

   // A register write restarts the read position
   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> ((read_idx_ff == '0) && (rd_crd_ff == '0)))
      else $error("register write did not restart reads");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int STORE_DEPTH = 4096;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CALM_AFTER = 1100;
   localparam int MAX_BLOCK = 64;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_AFTER_RESULTS = 100;

   // Index past the last defined register; a write there must change nothing
   localparam logic [taxp_pkg::CSR_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

   // One request as queued for the driver, with the result it must cause
   typedef struct {
      logic        action;
      logic [63:0] word;
      logic        makes_rsp;
      logic [63:0] word_due;
      logic        last_due;
   } request_type;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } target_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [taxp_pkg::PAYLOAD_W-1:0]  req_tdata = '0;
   logic                            req_tuser = taxp_pkg::ACT_LOAD;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [taxp_pkg::PAYLOAD_W-1:0]  rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we = 1'b0;
   logic [taxp_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [taxp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tensor_axis_permute_4d dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [63:0] word
      .req_tuser  (req_tuser),    // [0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [63:0] word_out
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the block: register copies, load and read positions and
   // the permuted store, plus a map of which store words hold data.
   // ------------------------------------------------------------------
   logic [3:0]  dim_reg [4];
   logic        swap_first_reg;
   logic        swap_second_reg;
   logic        swap_pairs_reg;
   int unsigned load_pos [4];
   int unsigned read_pos;
   logic [63:0] store_copy [STORE_DEPTH];
   bit          store_filled [STORE_DEPTH];

   request_type     req_backlog [$];
   target_word_type target_words_due [$];
   request_type     offered;
   logic            req_taken = 1'b0;

   int  item_count = 0;
   int  results_seen = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 25;
   int  recv_idle_pct = 25;
   bit  calm = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   function automatic int unsigned clamp_extent(logic [3:0] d);
      if (d == 4'd0) return 1;
      if (32'(d) > taxp_pkg::MAX_DIM_DEF) return taxp_pkg::MAX_DIM_DEF;
      return 32'(d);
   endfunction

   function automatic int unsigned clamped_product(logic [3:0] d0, logic [3:0] d1,
                                                   logic [3:0] d2, logic [3:0] d3);
      return clamp_extent(d0) * clamp_extent(d1) * clamp_extent(d2) * clamp_extent(d3);
   endfunction

   function automatic int unsigned block_size();
      return clamped_product(dim_reg[0], dim_reg[1], dim_reg[2], dim_reg[3]);
   endfunction

   function automatic void shadow_csr_write(logic [taxp_pkg::CSR_ADDR_W-1:0] idx,
                                            logic [taxp_pkg::CSR_DATA_W-1:0] val);
      bit known;
      known = 1'b1;
      case (idx)
         taxp_pkg::REG_DIM_ONE: dim_reg[0] = val;
         taxp_pkg::REG_DIM_TWO: dim_reg[1] = val;
         taxp_pkg::REG_DIM_THREE: dim_reg[2] = val;
         taxp_pkg::REG_DIM_FOUR: dim_reg[3] = val;
         taxp_pkg::REG_SWAP_FIRST: swap_first_reg = val[0];
         taxp_pkg::REG_SWAP_SECOND: swap_second_reg = val[0];
         taxp_pkg::REG_SWAP_PAIRS: swap_pairs_reg = val[0];
         default: known = 1'b0;
      endcase
      // any defined register restarts both positions
      if (known) begin
         foreach (load_pos[k]) load_pos[k] = 0;
         read_pos = 0;
      end
   endfunction

   // Address of the next load in the permuted layout
   function automatic int unsigned target_addr();
      int unsigned ord [4];
      int unsigned tmp;
      int unsigned addr;
      if (swap_pairs_reg) begin
         ord = '{2, 3, 0, 1};
      end else begin
         ord = '{0, 1, 2, 3};
      end
      if (swap_first_reg) begin
         tmp = ord[0];
         ord[0] = ord[1];
         ord[1] = tmp;
      end
      if (swap_second_reg) begin
         tmp = ord[2];
         ord[2] = ord[3];
         ord[3] = tmp;
      end
      addr = 0;
      for (int k = 0; k < 4; k++) begin
         addr = addr * clamp_extent(dim_reg[ord[k]]) + load_pos[ord[k]];
      end
      return addr;
   endfunction

   // Advance the shadow by one request and return it with its result
   function automatic request_type permute_step(logic action, logic [63:0] word);
      request_type r;
      int unsigned addr;
      int unsigned total;
      bit          carry;
      r.action = action;
      r.word = word;
      r.makes_rsp = 1'b0;
      r.word_due = '0;
      r.last_due = 1'b0;
      total = block_size();
      if (action == taxp_pkg::ACT_LOAD) begin
         addr = target_addr();
         store_copy[addr] = word;
         store_filled[addr] = 1'b1;
         // source axis four runs fastest
         carry = 1'b1;
         for (int k = 3; k >= 0; k--) begin
            if (carry) begin
               if (load_pos[k] + 1 < clamp_extent(dim_reg[k])) begin
                  load_pos[k]++;
                  carry = 1'b0;
               end else begin
                  load_pos[k] = 0;
               end
            end
         end
      end else begin
         if (read_pos >= total) read_pos = 0;
         r.makes_rsp = 1'b1;
         r.word_due = store_copy[read_pos];
         r.last_due = (read_pos + 1 == total);
         read_pos = r.last_due ? 0 : read_pos + 1;
      end
      return r;
   endfunction

   function automatic bit read_is_legal();
      int unsigned idx;
      idx = (read_pos >= block_size()) ? 0 : read_pos;
      return store_filled[idx];
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [3:0] pick_extent();
      case ($urandom_range(15))
         0: return 4'd0;
         1: return 4'($urandom_range(15, 9));
         2, 3: return 4'd8;
         default: return 4'($urandom_range(4, 1));
      endcase
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(3))
         0: return 0;
         1: return 10;
         2: return 25;
         default: return 50;
      endcase
   endfunction

   // Queue one request; turn a read of a never-loaded word into a load
   task automatic queue_request(logic action, logic [63:0] word);
      if (action == taxp_pkg::ACT_READ && !read_is_legal()) action = taxp_pkg::ACT_LOAD;
      req_backlog.push_back(permute_step(action, word));
      item_count++;
   endtask

   task automatic write_csr(logic [taxp_pkg::CSR_ADDR_W-1:0] idx,
                            logic [taxp_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      shadow_csr_write(idx, val);
   endtask

   task automatic end_csr();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every request is in and every result is out, then let the
   // read pipe settle before touching registers.
   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (req_backlog.size() != 0 || req_tvalid || target_words_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
   endtask

   task automatic configure_phase(int phase);
      logic [3:0]  dims [4];
      logic [3:0]  flag;
      logic [2:0]  combo;
      int unsigned prod;
      int          axis;
      for (int k = 0; k < 4; k++) begin
         dims[k] = $urandom_range(1) ? pick_extent() : dim_reg[k];
      end
      // keep blocks small enough that most of the run is many short blocks
      prod = clamped_product(dims[0], dims[1], dims[2], dims[3]);
      while (prod > MAX_BLOCK) begin
         axis = $urandom_range(3);
         dims[axis] = 4'($urandom_range(2, 1));
         prod = clamped_product(dims[0], dims[1], dims[2], dims[3]);
      end
      if ($urandom_range(3) == 0) write_csr(REG_UNMAPPED, 4'($urandom_range(15)));
      write_csr(taxp_pkg::REG_DIM_ONE, dims[0]);
      write_csr(taxp_pkg::REG_DIM_TWO, dims[1]);
      write_csr(taxp_pkg::REG_DIM_THREE, dims[2]);
      write_csr(taxp_pkg::REG_DIM_FOUR, dims[3]);
      // walk all eight orders first, then pick at random; upper bits are noise
      combo = (phase < 8) ? 3'(phase) : 3'($urandom_range(7));
      flag = 4'($urandom_range(15));
      flag[0] = combo[0];
      write_csr(taxp_pkg::REG_SWAP_FIRST, flag);
      flag = 4'($urandom_range(15));
      flag[0] = combo[1];
      write_csr(taxp_pkg::REG_SWAP_SECOND, flag);
      flag = 4'($urandom_range(15));
      flag[0] = combo[2];
      write_csr(taxp_pkg::REG_SWAP_PAIRS, flag);
      end_csr();
   endtask

   // Well-formed traffic: load a whole block, then read it out once or
   // twice with a few stray loads mixed in.
   task automatic fill_then_read();
      int unsigned total;
      int unsigned reads_left;
      total = block_size();
      for (int unsigned i = 0; i < total; i++) begin
         queue_request(taxp_pkg::ACT_LOAD, random_word());
      end
      reads_left = total * $urandom_range(2, 1);
      while (reads_left != 0) begin
         if ($urandom_range(9) == 0) begin
            queue_request(taxp_pkg::ACT_LOAD, random_word());
         end else begin
            queue_request(taxp_pkg::ACT_READ, random_word());
            reads_left--;
         end
      end
   endtask

   // Broken sequences: partial blocks, reads of stale words, free mixing
   task automatic mixed_traffic();
      int n;
      n = $urandom_range(120, 40);
      for (int i = 0; i < n; i++) begin
         queue_request($urandom_range(1) ? taxp_pkg::ACT_READ : taxp_pkg::ACT_LOAD,
                       random_word());
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver: present requests at the falling edge, hold each one
   // until it is taken, and insert idle bursts between requests.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered request
      end else if (send_gap > 0) begin
         send_gap = send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (req_backlog.size() != 0 && !calm &&
                   $urandom_range(99) < send_idle_pct) begin
         send_gap = $urandom_range(17, 1) - 1;
         req_tvalid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
         nxt = req_backlog.pop_front();
         offered <= nxt;
         req_tvalid <= 1'b1;
         req_tdata <= nxt.word;
         req_tuser <= nxt.action;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: random stall bursts, and once a long hold-off while
   // reads keep coming so the block fills and drops req_tready.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && !calm && results_seen >= HOLD_AFTER_RESULTS &&
                   rsp_tvalid && req_tvalid && offered.action == taxp_pkg::ACT_READ) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(99) < recv_idle_pct) begin
         stall_left = $urandom_range(17, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Acceptance and checking at the rising edge. Record the expected word
   // of a read request first, then compare any result leaving the block.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      target_word_type due;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready && offered.makes_rsp) begin
            due.word = offered.word_due;
            due.last = offered.last_due;
            target_words_due.push_back(due);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (target_words_due.size() == 0) begin
               $error("result with no read pending: word_out %h last %b",
                      rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               due = target_words_due.pop_front();
               if (rsp_tdata !== due.word) begin
                  $error("word_out mismatch: expected %h, actual %h", due.word, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== due.last) begin
                  $error("last mismatch: expected %b, actual %b", due.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus: reset, a short directed part, then random phases.
   // ------------------------------------------------------------------
   initial begin : stimulus
      int phase;
      foreach (dim_reg[k]) dim_reg[k] = 4'd1;
      swap_first_reg = 1'b0;
      swap_second_reg = 1'b0;
      swap_pairs_reg = 1'b0;
      foreach (load_pos[k]) load_pos[k] = 0;
      read_pos = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extent 0 taken as 1 and extent 9 taken as 8: an 8-word block.
      // Flag writes carry noise in the upper bits; only bit 0 counts.
      write_csr(taxp_pkg::REG_DIM_ONE, 4'd0);
      write_csr(taxp_pkg::REG_DIM_TWO, 4'd9);
      write_csr(taxp_pkg::REG_DIM_THREE, 4'd1);
      write_csr(taxp_pkg::REG_DIM_FOUR, 4'd1);
      write_csr(taxp_pkg::REG_SWAP_FIRST, 4'hF);
      write_csr(taxp_pkg::REG_SWAP_SECOND, 4'hE);
      write_csr(taxp_pkg::REG_SWAP_PAIRS, 4'h1);
      end_csr();
      queue_request(taxp_pkg::ACT_LOAD, 64'h0000_0000_0000_0000);
      queue_request(taxp_pkg::ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(taxp_pkg::ACT_LOAD, 64'h5555_5555_5555_5555);
      queue_request(taxp_pkg::ACT_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_request(taxp_pkg::ACT_LOAD, 64'h8000_0000_0000_0001);
      queue_request(taxp_pkg::ACT_LOAD, 64'h7FFF_FFFF_FFFF_FFFE);
      queue_request(taxp_pkg::ACT_LOAD, random_word());
      queue_request(taxp_pkg::ACT_LOAD, random_word());
      // read one past the end to wrap the read position
      repeat (9) queue_request(taxp_pkg::ACT_READ, random_word());
      // load past the end: wraps and overwrites the first word
      queue_request(taxp_pkg::ACT_LOAD, random_word());
      wait_idle();

      // unmapped register: positions must survive
      write_csr(REG_UNMAPPED, 4'hF);
      end_csr();
      repeat (2) queue_request(taxp_pkg::ACT_READ, random_word());
      wait_idle();

      // rewriting a register with its own value still restarts the block
      write_csr(taxp_pkg::REG_DIM_FOUR, 4'd1);
      end_csr();
      repeat (2) queue_request(taxp_pkg::ACT_READ, random_word());
      queue_request(taxp_pkg::ACT_LOAD, random_word());

      phase = 0;
      while (item_count < RANDOM_ITEMS) begin
         wait_idle();
         if (item_count >= CALM_AFTER) begin
            // no idling on either side near the end
            calm = 1'b1;
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = pick_pct();
            recv_idle_pct = pick_pct();
         end
         configure_phase(phase);
         if ($urandom_range(9) < 7) begin
            fill_then_read();
         end else begin
            mixed_traffic();
         end
         phase++;
      end

      // drain: all requests in, then a bounded wait for the last results
      @(posedge clock);
      #1;
      while (req_backlog.size() != 0 || req_tvalid) begin
         @(posedge clock);
         #1;
      end
      for (int n = 0; n < 2000 && target_words_due.size() != 0; n++) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
      if (target_words_due.size() != 0) begin
         $error("%0d read results never arrived", target_words_due.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
src/taxp_pkg.sv
src/taxp_load_addr.sv
src/tensor_axis_permute_4d.sv
dv/testbench.sv
